// ----- rtl/ssd_pkg.sv -----
package ssd_pkg;

    // Field widths fixed by the item formats
    localparam int ANGLE_W   = 20;
    localparam int RESP_W    = 16;
    localparam int DELAY_W   = 24;
    localparam int SPR_W     = 13;
    localparam int MSF_W     = 3;
    localparam int WAIT_W    = 25;
    localparam int STEPS_W   = 20;
    localparam int IDX_W     = 3;
    localparam int TDATA_W   = 32;

    // Angle fraction: the step count is the product shifted right by this much
    localparam int ANGLE_FRAC_BITS = 16;

    // angle * steps_per_rev, shifted left by up to the largest microstep factor
    localparam int PROD_W = ANGLE_W + SPR_W + (1 << MSF_W) - 1;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_RESPONSE_DELAY     = 3'd0;
    localparam logic [IDX_W-1:0] REG_STEP_DELAY         = 3'd1;
    localparam logic [IDX_W-1:0] REG_STABILITY_DELAY    = 3'd2;
    localparam logic [IDX_W-1:0] REG_STEPS_PER_REV      = 3'd3;
    localparam logic [IDX_W-1:0] REG_MICROSTEP_FACTOR   = 3'd4;
    localparam logic [IDX_W-1:0] REG_LIMIT_ACTIVE_LEVEL = 3'd5;

    // Register reset values
    localparam logic [RESP_W-1:0]  RST_RESPONSE_DELAY  = 16'd2;
    localparam logic [DELAY_W-1:0] RST_STEP_DELAY      = 24'd2000;
    localparam logic [DELAY_W-1:0] RST_STABILITY_DELAY = 24'd0;
    localparam logic [SPR_W-1:0]   RST_STEPS_PER_REV   = 13'd200;
    localparam logic [MSF_W-1:0]   RST_MICROSTEP       = 3'd0;
    localparam logic               RST_LIMIT_LEVEL     = 1'b0;

    typedef struct packed {
        logic [RESP_W-1:0]  response_delay;
        logic [DELAY_W-1:0] step_delay;
        logic [DELAY_W-1:0] stability_delay;
        logic [SPR_W-1:0]   steps_per_rev;
        logic [MSF_W-1:0]   microstep_factor;
        logic               limit_active_level;
    } ssd_cfg_t;

    typedef struct packed {
        logic               limit_level;
        logic               start_rotate;
        logic               start_home;
        logic [ANGLE_W-1:0] angle_turns;
        logic               set_enable;
        logic               motor_on;
    } ssd_item_t;

    typedef struct packed {
        logic               step_out;
        logic               dir_out;
        logic               enable_n;
        logic [MSF_W-1:0]   microstep_sel;
        logic               busy_res;
        logic               done_res;
        logic [STEPS_W-1:0] steps_done;
    } ssd_res_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ROT_LOW,
        PH_ROT_HIGH,
        PH_SETTLE,
        PH_HOME_LOW,
        PH_HOME_HIGH
    } phase_t;

endpackage

// ----- rtl/ssd_cfg_regs.sv -----
module ssd_cfg_regs
    import ssd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [DELAY_W-1:0]  cfg_data,
    output ssd_cfg_t            cfg
);

    ssd_cfg_t cfg_reg;

    // Writes are always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.response_delay     <= RST_RESPONSE_DELAY;
            cfg_reg.step_delay         <= RST_STEP_DELAY;
            cfg_reg.stability_delay    <= RST_STABILITY_DELAY;
            cfg_reg.steps_per_rev      <= RST_STEPS_PER_REV;
            cfg_reg.microstep_factor   <= RST_MICROSTEP;
            cfg_reg.limit_active_level <= RST_LIMIT_LEVEL;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RESPONSE_DELAY:     cfg_reg.response_delay     <= cfg_data[RESP_W-1:0];
                REG_STEP_DELAY:         cfg_reg.step_delay         <= cfg_data;
                REG_STABILITY_DELAY:    cfg_reg.stability_delay    <= cfg_data;
                REG_STEPS_PER_REV:      cfg_reg.steps_per_rev      <= cfg_data[SPR_W-1:0];
                REG_MICROSTEP_FACTOR:   cfg_reg.microstep_factor   <= cfg_data[MSF_W-1:0];
                REG_LIMIT_ACTIVE_LEVEL: cfg_reg.limit_active_level <= cfg_data[0];
                default:                ;
            endcase
        end
    end

endmodule

// ----- rtl/ssd_in_stage.sv -----
module ssd_in_stage
    import ssd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,
    input  logic               advance,
    output logic               item_valid,
    output ssd_item_t          item
);

    logic      valid_reg;
    ssd_item_t item_reg;
    ssd_item_t item_unpacked;

    // Free, or emptying this cycle
    assign s_axis_tready = !valid_reg || advance;
    assign item_valid    = valid_reg;
    assign item          = item_reg;

    // tdata layout, low bits first
    always_comb
    begin
        item_unpacked.limit_level  = s_axis_tdata[0];
        item_unpacked.start_rotate = s_axis_tdata[1];
        item_unpacked.start_home   = s_axis_tdata[2];
        item_unpacked.angle_turns  = s_axis_tdata[ANGLE_W+2:3];
        item_unpacked.set_enable   = s_axis_tdata[ANGLE_W+3];
        item_unpacked.motor_on     = s_axis_tdata[ANGLE_W+4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg <= item_unpacked;
        end
    end

endmodule

// ----- rtl/ssd_core.sv -----
module ssd_core
    import ssd_pkg::*;
#(
    parameter int STEP_COUNT_BITS = 20
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  ssd_item_t item,
    input  ssd_cfg_t  cfg,
    output ssd_res_t  res
);

    localparam logic [STEP_COUNT_BITS-1:0] CNT_MAX = {STEP_COUNT_BITS{1'b1}};
    localparam logic [PROD_W-1:0] CNT_MAX_P =
        (PROD_W'(1) << STEP_COUNT_BITS) - PROD_W'(1);

    phase_t                     phase_reg, phase_next;
    logic [WAIT_W-1:0]          wait_reg, wait_next;
    logic [STEP_COUNT_BITS-1:0] target_reg, target_next;
    logic [STEP_COUNT_BITS-1:0] count_reg, count_next;
    logic                       step_reg, step_next;
    logic                       dir_reg, dir_next;
    logic                       en_n_reg, en_n_next;
    logic                       home_stage_reg, home_stage_next;
    logic                       done_next;

    logic                       active;
    logic [WAIT_W-1:0]          low_m1;
    logic [WAIT_W-1:0]          high_sum;
    logic [WAIT_W-1:0]          high_m1;
    logic [ANGLE_W+SPR_W-1:0]   product;
    logic [PROD_W-1:0]          scaled;
    logic [PROD_W-1:0]          whole_steps;
    logic [STEP_COUNT_BITS-1:0] target_calc;
    logic [STEP_COUNT_BITS-1:0] count_inc;
    logic                       go_step;
    logic                       go_settle;
    logic [31:0]                count_ext;

    assign active = (item.limit_level == cfg.limit_active_level);

    // Phase lengths, each at least one tick
    assign low_m1   = (cfg.response_delay == '0) ? '0
                    : WAIT_W'(cfg.response_delay) - WAIT_W'(1);
    assign high_sum = WAIT_W'(cfg.response_delay) + WAIT_W'(cfg.step_delay);
    assign high_m1  = (high_sum == '0) ? '0 : high_sum - WAIT_W'(1);

    // Step target: angle * steps/rev * 2^microstep, drop the fraction, saturate
    assign product     = (ANGLE_W+SPR_W)'(item.angle_turns) * (ANGLE_W+SPR_W)'(cfg.steps_per_rev);
    assign scaled      = PROD_W'(product) << cfg.microstep_factor;
    assign whole_steps = scaled >> ANGLE_FRAC_BITS;
    assign target_calc = (whole_steps > CNT_MAX_P) ? CNT_MAX
                       : whole_steps[STEP_COUNT_BITS-1:0];

    assign count_inc = (count_reg != CNT_MAX) ? count_reg + STEP_COUNT_BITS'(1) : count_reg;

    // Phase register and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            wait_reg       <= '0;
            target_reg     <= '0;
            count_reg      <= '0;
            step_reg       <= 1'b0;
            dir_reg        <= 1'b0;
            en_n_reg       <= 1'b1;
            home_stage_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            wait_reg       <= wait_next;
            target_reg     <= target_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            dir_reg        <= dir_next;
            en_n_reg       <= en_n_next;
            home_stage_reg <= home_stage_next;
        end
    end

    // Next state for one tick
    always_comb
    begin
        phase_next      = phase_reg;
        wait_next       = wait_reg;
        target_next     = target_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        dir_next        = dir_reg;
        en_n_next       = en_n_reg;
        home_stage_next = home_stage_reg;
        done_next       = 1'b0;
        go_step         = 1'b0;
        go_settle       = 1'b0;

        if (item.set_enable)
        begin
            en_n_next = !item.motor_on;
        end

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (item.start_rotate)
                begin
                    target_next = target_calc;
                    count_next  = '0;
                    if (target_calc != '0 && !active)
                    begin
                        go_step = 1'b1;
                    end
                    else
                    begin
                        go_settle = 1'b1;
                    end
                end
                else if (item.start_home)
                begin
                    // first step always made; switch already hit flips to release stage
                    home_stage_next = active;
                    dir_next        = !active;
                    step_next       = 1'b0;
                    wait_next       = low_m1;
                    phase_next      = PH_HOME_LOW;
                end
            end
            PH_ROT_LOW, PH_HOME_LOW:
            begin
                if (wait_reg != '0)
                begin
                    wait_next = wait_reg - WAIT_W'(1);
                end
                else
                begin
                    step_next  = 1'b1;
                    wait_next  = high_m1;
                    phase_next = (phase_reg == PH_ROT_LOW) ? PH_ROT_HIGH : PH_HOME_HIGH;
                end
            end
            PH_ROT_HIGH:
            begin
                if (wait_reg != '0)
                begin
                    wait_next = wait_reg - WAIT_W'(1);
                end
                else
                begin
                    count_next = count_inc;
                    if (count_inc < target_reg && !active)
                    begin
                        go_step = 1'b1;
                    end
                    else
                    begin
                        go_settle = 1'b1;
                    end
                end
            end
            PH_HOME_HIGH:
            begin
                if (wait_reg != '0)
                begin
                    wait_next = wait_reg - WAIT_W'(1);
                end
                else if (home_stage_reg && !active)
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    if (!home_stage_reg && active)
                    begin
                        home_stage_next = 1'b1;
                        dir_next        = 1'b0;
                    end
                    step_next  = 1'b0;
                    wait_next  = low_m1;
                    phase_next = PH_HOME_LOW;
                end
            end
            PH_SETTLE:
            begin
                if (wait_reg <= WAIT_W'(1))
                begin
                    wait_next  = '0;
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    wait_next = wait_reg - WAIT_W'(1);
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // Start of a rotation step
        if (go_step)
        begin
            step_next  = 1'b0;
            wait_next  = low_m1;
            phase_next = PH_ROT_LOW;
        end

        // End of a rotation: wait for the mechanics to settle
        if (go_settle)
        begin
            wait_next = WAIT_W'(cfg.stability_delay);
            if (cfg.stability_delay == '0)
            begin
                phase_next = PH_IDLE;
                done_next  = 1'b1;
            end
            else
            begin
                phase_next = PH_SETTLE;
            end
        end
    end

    // Result reflects the state after the tick
    assign count_ext = 32'(count_next);

    always_comb
    begin
        res.step_out      = step_next;
        res.dir_out       = dir_next;
        res.enable_n      = en_n_next;
        res.microstep_sel = cfg.microstep_factor;
        res.busy_res      = (phase_next != PH_IDLE);
        res.done_res      = done_next;
        res.steps_done    = count_ext[STEPS_W-1:0];
    end

endmodule

// ----- rtl/ssd_out_stage.sv -----
module ssd_out_stage
    import ssd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  ssd_res_t           res,
    output logic               out_ready,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata
);

    logic     valid_reg;
    ssd_res_t res_reg;

    assign out_ready     = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;

    // tdata layout, low bits first, zero filled to 32 bits
    assign m_axis_tdata = TDATA_W'({res_reg.steps_done, res_reg.done_res, res_reg.busy_res,
                                    res_reg.microstep_sel, res_reg.enable_n,
                                    res_reg.dir_out, res_reg.step_out});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

endmodule

// ----- rtl/stepper_step_dir_sequencer.sv -----
// A request accepted on s_axis is held in the input register, then passes through the core
// into the result register, from which m_axis presents it.
// Throughput: one tick request per cycle unless m_axis stalls a result; the step target
// multiply and phase counter update sit in one pass between input and result registers.
// Reset: asynchronous, active low; phase idle, counters zero, step and dir low,
// enable_n high, configuration registers at their defaults, both stages empty.
module stepper_step_dir_sequencer
    import ssd_pkg::*;
#(
    parameter int STEP_COUNT_BITS = 20
)
(
    input  logic               clk,
    input  logic               rst_n,
    // tdata: limit_level[0], start_rotate[1], start_home[2], angle_turns[22:3],
    //        set_enable[23], motor_on[24], zero[31:25]
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,
    // tdata: step_out[0], dir_out[1], enable_n[2], microstep_sel[5:3], busy_res[6],
    //        done_res[7], steps_done[27:8], zero[31:28]
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [DELAY_W-1:0] cfg_data
);

    ssd_cfg_t  cfg;
    ssd_item_t item;
    ssd_res_t  res;
    logic      item_valid;
    logic      out_ready;
    logic      advance;

    // One tick moves from input register to result register
    assign advance = item_valid && out_ready;

    ssd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ssd_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    ssd_core #(
        .STEP_COUNT_BITS (STEP_COUNT_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .cfg     (cfg),
        .res     (res)
    );

    ssd_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .res           (res),
        .out_ready     (out_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- rtl/ssd_checker.sv -----
module ssd_checker
    import ssd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tready,
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [TDATA_W-1:0] m_axis_tdata
);

    logic               prev_valid_reg;
    logic               prev_busy_reg;
    logic [STEPS_W-1:0] prev_steps_reg;
    logic               m_take;

    assign m_take = m_axis_tvalid && m_axis_tready;

    // Last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= 1'b0;
            prev_busy_reg  <= 1'b0;
            prev_steps_reg <= '0;
        end
        else if (m_take)
        begin
            prev_valid_reg <= 1'b1;
            prev_busy_reg  <= m_axis_tdata[6];
            prev_steps_reg <= m_axis_tdata[STEPS_W+7:8];
        end
    end

    // Done only ever comes with the sequencer back at idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[7] |-> !m_axis_tdata[6])
        else $error("done shown while busy");

    // Input side only stalls behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with output empty");

    // Idle to idle without done leaves the step count alone
    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_take && prev_valid_reg && !prev_busy_reg && !m_axis_tdata[6] && !m_axis_tdata[7]
        |-> m_axis_tdata[STEPS_W+7:8] == prev_steps_reg)
        else $error("step count changed while idle");

    // A held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

endmodule

bind stepper_step_dir_sequencer ssd_checker u_ssd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import ssd_pkg::*;

    // Cycles without any request moving before the run is abandoned
    localparam int QUIET_LIMIT = 1000;
    // Indexes past the register list; the block must ignore them
    localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;
    localparam logic [63:0] STEP_SAT = (64'd1 << STEPS_W) - 64'd1;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    // tdata: limit_level, start_rotate, start_home, angle_turns, set_enable, motor_on
    logic [TDATA_W-1:0] s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // tdata: step_out, dir_out, enable_n, microstep_sel, busy_res, done_res, steps_done
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [DELAY_W-1:0] cfg_data = '0;

    // Shadow of the sequencer: registers and motion state
    ssd_cfg_t cfg_shadow = '{RST_RESPONSE_DELAY, RST_STEP_DELAY, RST_STABILITY_DELAY,
                             RST_STEPS_PER_REV, RST_MICROSTEP, RST_LIMIT_LEVEL};
    phase_t              motion_ph = PH_IDLE;
    logic [WAIT_W-1:0]   wait_cnt = '0;
    logic [STEPS_W:0]    target_cnt = '0;
    logic [STEPS_W-1:0]  steps_made = '0;
    logic                step_lvl = 1'b0;
    logic                dir_lvl = 1'b0;
    logic                en_n = 1'b1;
    logic                seek_done = 1'b0;
    logic                pulse_done = 1'b0;

    ssd_res_t pins_due[$];
    ssd_res_t pin_want;

    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    int rx_stall = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int ticks_checked = 0;
    int done_pulses = 0;
    int rotations = 0;
    int homings = 0;
    int reg_writes = 0;

    stepper_step_dir_sequencer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Sequencer prediction
    // ---------------------------------------------------------------

    // Step goes low for max(response_delay,1) ticks
    function automatic void load_step(input bit homing);
        step_lvl = 1'b0;
        wait_cnt = (cfg_shadow.response_delay == 0) ? '0 :
                   WAIT_W'(cfg_shadow.response_delay) - 1'b1;
        motion_ph = homing ? PH_HOME_LOW : PH_ROT_LOW;
    endfunction

    // Next step of a rotation, or the settle wait
    function automatic void next_rotation_step(input logic at_limit);
        if (steps_made < target_cnt && !at_limit)
            load_step(1'b0);
        else
        begin
            wait_cnt = WAIT_W'(cfg_shadow.stability_delay);
            if (wait_cnt == 0)
            begin
                motion_ph = PH_IDLE;
                pulse_done = 1'b1;
            end
            else
                motion_ph = PH_SETTLE;
        end
    endfunction

    // Homing: seek the switch with dir high, then back off with dir low
    function automatic void next_homing_step(input logic at_limit);
        if (!seek_done && at_limit)
        begin
            seek_done = 1'b1;
            dir_lvl = 1'b0;
        end
        if (seek_done && !at_limit)
        begin
            motion_ph = PH_IDLE;
            pulse_done = 1'b1;
        end
        else
            load_step(1'b1);
    endfunction

    function automatic ssd_res_t sequencer_tick(input ssd_item_t it);
        logic              at_limit;
        logic [63:0]       wide;
        logic [WAIT_W-1:0] hold;
        ssd_res_t          r;
        at_limit = (it.limit_level == cfg_shadow.limit_active_level);
        pulse_done = 1'b0;
        if (it.set_enable)
            en_n = ~it.motor_on;

        case (motion_ph)
            PH_IDLE:
            begin
                if (it.start_rotate)
                begin
                    wide = (64'(it.angle_turns) * 64'(cfg_shadow.steps_per_rev))
                           << cfg_shadow.microstep_factor;
                    wide = wide >> ANGLE_FRAC_BITS;
                    target_cnt = (wide > STEP_SAT) ? STEP_SAT[STEPS_W:0] : wide[STEPS_W:0];
                    steps_made = '0;
                    rotations++;
                    next_rotation_step(at_limit);
                end
                else if (it.start_home)
                begin
                    dir_lvl = 1'b1;
                    seek_done = 1'b0;
                    homings++;
                    next_homing_step(at_limit);
                end
            end
            PH_ROT_LOW, PH_HOME_LOW:
            begin
                if (wait_cnt != 0)
                    wait_cnt = wait_cnt - 1'b1;
                else
                begin
                    // high for max(response_delay + step_delay, 1) ticks
                    step_lvl = 1'b1;
                    hold = WAIT_W'(cfg_shadow.response_delay) + WAIT_W'(cfg_shadow.step_delay);
                    wait_cnt = (hold == 0) ? '0 : hold - 1'b1;
                    motion_ph = (motion_ph == PH_ROT_LOW) ? PH_ROT_HIGH : PH_HOME_HIGH;
                end
            end
            PH_ROT_HIGH:
            begin
                if (wait_cnt != 0)
                    wait_cnt = wait_cnt - 1'b1;
                else
                begin
                    if (steps_made != '1)
                        steps_made = steps_made + 1'b1;
                    next_rotation_step(at_limit);
                end
            end
            PH_HOME_HIGH:
            begin
                if (wait_cnt != 0)
                    wait_cnt = wait_cnt - 1'b1;
                else
                    next_homing_step(at_limit);
            end
            PH_SETTLE:
            begin
                if (wait_cnt != 0)
                    wait_cnt = wait_cnt - 1'b1;
                if (wait_cnt == 0)
                begin
                    motion_ph = PH_IDLE;
                    pulse_done = 1'b1;
                end
            end
            default:
                motion_ph = PH_IDLE;
        endcase

        r.step_out      = step_lvl;
        r.dir_out       = dir_lvl;
        r.enable_n      = en_n;
        r.microstep_sel = cfg_shadow.microstep_factor;
        r.busy_res      = (motion_ph != PH_IDLE);
        r.done_res      = pulse_done;
        r.steps_done    = steps_made;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result checking and output back-pressure
    // ---------------------------------------------------------------

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pins_due.size() == 0)
                begin
                    $display("%0t: result with nothing expected, expected none, got tdata %h",
                             $time, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    pin_want = pins_due.pop_front();
                    check_field("step_out", 32'(pin_want.step_out), 32'(m_axis_tdata[0]));
                    check_field("dir_out", 32'(pin_want.dir_out), 32'(m_axis_tdata[1]));
                    check_field("enable_n", 32'(pin_want.enable_n), 32'(m_axis_tdata[2]));
                    check_field("microstep_sel", 32'(pin_want.microstep_sel),
                                32'(m_axis_tdata[5:3]));
                    check_field("busy_res", 32'(pin_want.busy_res), 32'(m_axis_tdata[6]));
                    check_field("done_res", 32'(pin_want.done_res), 32'(m_axis_tdata[7]));
                    check_field("steps_done", 32'(pin_want.steps_done),
                                32'(m_axis_tdata[27:8]));
                    if (pin_want.done_res)
                        done_pulses++;
                    ticks_checked++;
                end
                rx_stall = rx_gaps ? $urandom_range(0, 14) : 0;
                if (rx_stall != 0)
                    m_axis_tready <= 1'b0;
            end
            else if (!m_axis_tready)
            begin
                if (rx_stall > 1)
                    rx_stall--;
                else
                begin
                    rx_stall = 0;
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Watchdog on any request moving
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
            $display("[stepper_step_dir_sequencer] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic ssd_item_t tick_of(input logic lim, input logic rot, input logic home,
                                          input logic [ANGLE_W-1:0] ang,
                                          input logic set_en, input logic on);
        ssd_item_t it;
        it.limit_level  = lim;
        it.start_rotate = rot;
        it.start_home   = home;
        it.angle_turns  = ang;
        it.set_enable   = set_en;
        it.motor_on     = on;
        return it;
    endfunction

    // Switch level that reads as reached (1) or clear (0) under the current setting
    function automatic logic switch_level(input bit active);
        return active ? cfg_shadow.limit_active_level : ~cfg_shadow.limit_active_level;
    endfunction

    task automatic send_tick(input ssd_item_t it);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 14) : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, it.motor_on, it.set_enable, it.angle_turns,
                          it.start_home, it.start_rotate, it.limit_level};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pins_due.push_back(sequencer_tick(it));
    endtask

    // Stop sending and let every outstanding result come back
    task automatic drain_and_pause();
        s_axis_tvalid <= 1'b0;
        while (pins_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DELAY_W-1:0] val);
        drain_and_pause();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_RESPONSE_DELAY:     cfg_shadow.response_delay     = val[RESP_W-1:0];
            REG_STEP_DELAY:         cfg_shadow.step_delay         = val;
            REG_STABILITY_DELAY:    cfg_shadow.stability_delay    = val;
            REG_STEPS_PER_REV:      cfg_shadow.steps_per_rev      = val[SPR_W-1:0];
            REG_MICROSTEP_FACTOR:   cfg_shadow.microstep_factor   = val[MSF_W-1:0];
            REG_LIMIT_ACTIVE_LEVEL: cfg_shadow.limit_active_level = val[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_setting(input logic [RESP_W-1:0] rd, input logic [DELAY_W-1:0] sd,
                                 input logic [DELAY_W-1:0] stab, input logic [SPR_W-1:0] spr,
                                 input logic [MSF_W-1:0] msf, input logic lvl);
        write_reg(REG_RESPONSE_DELAY, DELAY_W'(rd));
        write_reg(REG_STEP_DELAY, sd);
        write_reg(REG_STABILITY_DELAY, stab);
        write_reg(REG_STEPS_PER_REV, DELAY_W'(spr));
        write_reg(REG_MICROSTEP_FACTOR, DELAY_W'(msf));
        write_reg(REG_LIMIT_ACTIVE_LEVEL, DELAY_W'(lvl));
    endtask

    // Tick on until the motion ends; homing sees the switch reached then released,
    // a rotation runs to its target or, with stop_early, hits the switch
    task automatic run_out(input bit stop_early);
        bit want_active;
        for (int n = 0; n < 300 && motion_ph != PH_IDLE; n++)
        begin
            if (motion_ph == PH_HOME_LOW || motion_ph == PH_HOME_HIGH)
                want_active = !seek_done;
            else
                want_active = stop_early;
            send_tick(tick_of(switch_level(want_active), 1'b0, 1'b0, '0, 1'b0, 1'b0));
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset values, enable control and a zero-angle rotation at default registers
    task automatic test_reset_defaults();
        send_tick(tick_of(1'b1, 1'b0, 1'b0, '0, 1'b0, 1'b0));
        send_tick(tick_of(1'b1, 1'b0, 1'b0, '0, 1'b1, 1'b1));
        send_tick(tick_of(1'b1, 1'b1, 1'b0, '0, 1'b0, 1'b0));
        send_tick(tick_of(1'b0, 1'b0, 1'b0, '0, 1'b1, 1'b0));
    endtask

    // Zero delays: single and double steps, both strobes, commands while busy,
    // and the switch already reached at the start
    task automatic test_short_moves();
        apply_setting('0, '0, '0, 13'd200, 3'd0, 1'b1);
        send_tick(tick_of(switch_level(1'b0), 1'b1, 1'b0, 20'd328, 1'b1, 1'b1));
        run_out(1'b0);
        // rotate wins over home
        send_tick(tick_of(switch_level(1'b0), 1'b1, 1'b1, 20'd656, 1'b0, 1'b0));
        send_tick(tick_of(switch_level(1'b0), 1'b1, 1'b1, ANGLE_MAX, 1'b1, 1'b0));
        send_tick(tick_of(switch_level(1'b0), 1'b0, 1'b0, '0, 1'b1, 1'b1));
        run_out(1'b0);
        send_tick(tick_of(switch_level(1'b1), 1'b1, 1'b0, 20'd328, 1'b0, 1'b0));
    endtask

    // Homing from a clear switch and from a switch already reached
    task automatic test_homing();
        send_tick(tick_of(switch_level(1'b0), 1'b0, 1'b1, '0, 1'b0, 1'b0));
        send_tick(tick_of(switch_level(1'b0), 1'b0, 1'b0, '0, 1'b0, 1'b0));
        send_tick(tick_of(switch_level(1'b0), 1'b1, 1'b1, 20'd5, 1'b0, 1'b0));
        run_out(1'b0);
        send_tick(tick_of(switch_level(1'b1), 1'b0, 1'b1, '0, 1'b0, 1'b0));
        run_out(1'b0);
    endtask

    // Saturated target with microstep factor above four, then zero steps_per_rev
    // with a settle wait
    task automatic test_extreme_targets();
        apply_setting('0, '0, '0, 13'd4096, 3'd7, 1'b0);
        send_tick(tick_of(switch_level(1'b0), 1'b1, 1'b0, ANGLE_MAX, 1'b0, 1'b0));
        run_out(1'b1);
        apply_setting('0, '0, 24'd3, '0, 3'd2, 1'b0);
        send_tick(tick_of(switch_level(1'b0), 1'b1, 1'b0, ANGLE_MAX, 1'b0, 1'b0));
        run_out(1'b0);
    endtask

    // Random ticks over several settings; the switch mostly stays clear with short spells reached
    task automatic test_random_traffic();
        logic [RESP_W-1:0]  rd;
        logic [DELAY_W-1:0] sd;
        logic [DELAY_W-1:0] stab;
        logic [SPR_W-1:0]   spr;
        logic [MSF_W-1:0]   msf;
        logic               lvl;
        int unsigned        scale;
        int unsigned        small_angle;
        bit                 sw_active;
        logic               lim;
        logic               rot;
        logic               home;
        logic [ANGLE_W-1:0] ang;
        sw_active = 1'b0;
        for (int setting = 0; setting < 6; setting++)
        begin
            case (setting)
                0: begin rd = 0; sd = 0; stab = 0; spr = 200; msf = 0; lvl = 0; end
                1: begin rd = 1; sd = 2; stab = 3; spr = 200; msf = 4; lvl = 1; end
                2: begin rd = 0; sd = 0; stab = 1; spr = 0; msf = 2; lvl = 0; end
                5: begin rd = 2; sd = 1; stab = 0; spr = 4096; msf = 4; lvl = 1; end
                default:
                begin
                    rd   = RESP_W'($urandom_range(0, 3));
                    sd   = DELAY_W'($urandom_range(0, 5));
                    stab = DELAY_W'($urandom_range(0, 6));
                    spr  = (setting == 3) ? SPR_W'($urandom_range(0, 4096))
                                          : SPR_W'($urandom_range(1, 400));
                    msf  = MSF_W'($urandom_range(0, 7));
                    lvl  = 1'($urandom_range(0, 1));
                end
            endcase
            apply_setting(rd, sd, stab, spr, msf, lvl);

            // angle range that gives a handful of steps
            scale = int'(spr) << msf;
            small_angle = (scale == 0) ? 32'hFFFFF : (6 * 65536) / scale;
            if (small_angle == 0)
                small_angle = 1;
            if (small_angle > 32'hFFFFF)
                small_angle = 32'hFFFFF;

            for (int k = 0; k < 65; k++)
            begin
                if (k % 20 == 0)
                begin
                    tx_gaps = ($urandom_range(0, 3) != 0);
                    rx_gaps = ($urandom_range(0, 3) != 0);
                end
                if (sw_active)
                    sw_active = ($urandom_range(0, 3) != 0);
                else
                    sw_active = ($urandom_range(0, 19) == 0);
                lim = switch_level(sw_active);
                if ($urandom_range(0, 15) == 0)
                    lim = 1'($urandom_range(0, 1));
                if (motion_ph == PH_IDLE)
                begin
                    rot  = ($urandom_range(0, 2) == 0);
                    home = ($urandom_range(0, 5) == 0);
                end
                else
                begin
                    rot  = ($urandom_range(0, 9) == 0);
                    home = ($urandom_range(0, 9) == 0);
                end
                ang = ($urandom_range(0, 7) == 0) ? ANGLE_W'($urandom_range(0, 32'hFFFFF))
                                                  : ANGLE_W'($urandom_range(0, small_angle));
                send_tick(tick_of(lim, rot, home, ang, $urandom_range(0, 5) == 0,
                                  1'($urandom_range(0, 1))));
            end
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    // Largest delays and register values, spare indexes ignored; the move
    // started here stays in its long low phase to the end of the run
    task automatic test_extreme_delays();
        run_out(1'b1);
        apply_setting('1, '1, '1, 13'h1FFF, 3'd7, 1'b1);
        write_reg(REG_SPARE_6, DELAY_W'($urandom_range(0, 32'hFFFFFF)));
        write_reg(REG_SPARE_7, DELAY_W'($urandom_range(0, 32'hFFFFFF)));
        send_tick(tick_of(switch_level(1'b0), 1'b1, 1'b0, ANGLE_MAX, 1'b1, 1'b1));
        for (int k = 0; k < 20; k++)
            send_tick(tick_of(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)),
                              ANGLE_W'($urandom_range(0, 32'hFFFFF)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_short_moves();
        test_homing();
        test_extreme_targets();
        test_random_traffic();
        test_extreme_delays();

        drain_and_pause();
        repeat (8) @(posedge clk);

        $display("%0d ticks checked across %0d register writes", ticks_checked, reg_writes);
        $display("%0d rotations and %0d homing runs started, %0d done pulses seen",
                 rotations, homings, done_pulses);
        if (mismatches == 0 && pins_due.size() == 0)
            $display("[stepper_step_dir_sequencer] OK");
        else
        begin
            $display("%0d mismatches, %0d results still outstanding", mismatches,
                     pins_due.size());
            $display("[stepper_step_dir_sequencer] ERROR");
        end
        $finish;
    end

endmodule
